### design/qoid_pkg.sv
// shared types, codes and helper functions for the qoi rgb565 decoder
// no dependencies; imported by every module of the block but qoid_ram
package qoid_pkg;

    localparam int INDEX_ENTRIES_DEF = 64;

    // chunk kinds held while operand bytes are collected
    localparam logic [1:0] KIND_RGB  = 2'd0;
    localparam logic [1:0] KIND_RGBA = 2'd1;
    localparam logic [1:0] KIND_LUMA = 2'd2;

    // end-of-image status codes
    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_EXTRA   = 2'd1;
    localparam logic [1:0] ST_SHORT   = 2'd2;
    localparam logic [1:0] ST_OVERRUN = 2'd3;

    // full-byte opcodes and two-bit tags
    localparam logic [7:0] OP_RGB    = 8'hFE;
    localparam logic [7:0] OP_RGBA   = 8'hFF;
    localparam logic [1:0] TAG_INDEX = 2'b00;
    localparam logic [1:0] TAG_DIFF  = 2'b01;
    localparam logic [1:0] TAG_LUMA  = 2'b10;
    localparam logic [1:0] TAG_RUN   = 2'b11;

    // configuration register indexes
    localparam logic REG_WIDTH  = 1'b0;
    localparam logic REG_HEIGHT = 1'b1;

    localparam logic [31:0] PREV_RESET = 32'hFF00_0000;

    // decode outcome for one byte
    typedef struct packed {
        logic [31:0] prev;
        logic [2:0]  phase;
        logic [1:0]  kind;
        logic [5:0]  luma;
        logic [6:0]  reps;
        logic        extra;
    } t_dec;

    // index hash 3r+5g+7b+11a, kept to eight bits
    function automatic logic [7:0] hash8(input logic [31:0] rgba);
        logic [7:0] r;
        logic [7:0] g;
        logic [7:0] b;
        logic [7:0] a;
        r = rgba[7:0];
        g = rgba[15:8];
        b = rgba[23:16];
        a = rgba[31:24];
        return r * 8'd3 + g * 8'd5 + b * 8'd7 + a * 8'd11;
    endfunction

    function automatic logic [15:0] to565(input logic [31:0] rgba);
        return {rgba[7:3], rgba[15:10], rgba[23:19]};
    endfunction

endpackage

### design/qoid_ram.sv
// generic single-write, single-read synchronous ram with registered read
// no dependencies
module qoid_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64,
    parameter int AW    = $clog2(DEPTH)
) (
    input  logic             i_clk,
    input  logic             i_wr_en,
    input  logic [AW-1:0]    i_wr_addr,
    input  logic [WIDTH-1:0] i_wr_data,
    input  logic             i_rd_en,
    input  logic [AW-1:0]    i_rd_addr,
    output logic [WIDTH-1:0] o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

### design/qoid_index.sv
// colour index: ram plus one valid bit per entry, cleared per image
// depends on qoid_pkg and qoid_ram
module qoid_index
    import qoid_pkg::*;
#(
    parameter int INDEX_ENTRIES = INDEX_ENTRIES_DEF,
    parameter int AW            = $clog2(INDEX_ENTRIES)
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_clr,
    input  logic          i_rd_en,
    input  logic [AW-1:0] i_rd_addr,
    output logic [31:0]   o_rd_data,
    input  logic          i_wr_en,
    input  logic [AW-1:0] i_wr_addr,
    input  logic [31:0]   i_wr_data
);

    logic [INDEX_ENTRIES-1:0] r_valid;
    logic                     r_hit;
    logic [31:0]              w_ram_q;

    qoid_ram #(
        .WIDTH (32),
        .DEPTH (INDEX_ENTRIES),
        .AW    (AW)
    ) u_ram (
        .i_clk     (i_clk),
        .i_wr_en   (i_wr_en),
        .i_wr_addr (i_wr_addr),
        .i_wr_data (i_wr_data),
        .i_rd_en   (i_rd_en),
        .i_rd_addr (i_rd_addr),
        .o_rd_data (w_ram_q)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_clr) begin
            r_valid <= '0;
        end else if (i_wr_en) begin
            r_valid[i_wr_addr] <= 1'b1;
        end
    end

    // hit flag is registered alongside the ram read data
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hit <= 1'b0;
        end else if (i_rd_en) begin
            r_hit <= r_valid[i_rd_addr];
        end
    end

    // entries not written this image read as zero
    assign o_rd_data = r_hit ? w_ram_q : 32'd0;

endmodule

### design/qoid_decode.sv
// chunk decoder: next pixel, chunk progress and repeat count for one byte
// depends on qoid_pkg
module qoid_decode
    import qoid_pkg::*;
(
    input  logic [7:0]  i_byte,
    input  logic [31:0] i_prev,
    input  logic [31:0] i_idx_data,
    input  logic [2:0]  i_phase,
    input  logic [1:0]  i_kind,
    input  logic [5:0]  i_luma,
    input  logic        i_img_full,
    output t_dec        o_dec
);

    logic [2:0] w_ph_m1;
    logic [1:0] w_sel;
    logic [7:0] w_dr;
    logic [7:0] w_dg;
    logic [7:0] w_db;
    logic [7:0] w_lg;

    always_comb begin
        w_ph_m1 = i_phase - 3'd1;
        w_sel   = w_ph_m1[1:0];
        // diff biases of two, luma biases of 32 and 8 (mod 256)
        w_dr    = {6'd0, i_byte[5:4]} - 8'd2;
        w_dg    = {6'd0, i_byte[3:2]} - 8'd2;
        w_db    = {6'd0, i_byte[1:0]} - 8'd2;
        w_lg    = {2'd0, i_luma} - 8'd32;

        o_dec       = '0;
        o_dec.prev  = i_prev;
        o_dec.phase = i_phase;
        o_dec.kind  = i_kind;
        o_dec.luma  = i_luma;

        if (i_phase == 3'd0) begin
            if (i_img_full) begin
                o_dec.extra = 1'b1;
            end else if (i_byte == OP_RGB) begin
                o_dec.kind  = KIND_RGB;
                o_dec.phase = 3'd1;
            end else if (i_byte == OP_RGBA) begin
                o_dec.kind  = KIND_RGBA;
                o_dec.phase = 3'd1;
            end else begin
                case (i_byte[7:6])
                    TAG_INDEX: begin
                        o_dec.prev = i_idx_data;
                        o_dec.reps = 7'd1;
                    end
                    TAG_DIFF: begin
                        o_dec.prev = {i_prev[31:24], i_prev[23:16] + w_db,
                                      i_prev[15:8] + w_dg, i_prev[7:0] + w_dr};
                        o_dec.reps = 7'd1;
                    end
                    TAG_LUMA: begin
                        o_dec.luma  = i_byte[5:0];
                        o_dec.kind  = KIND_LUMA;
                        o_dec.phase = 3'd1;
                    end
                    default: begin
                        o_dec.reps = {1'b0, i_byte[5:0]} + 7'd1;
                    end
                endcase
            end
        end else if (i_kind == KIND_LUMA) begin
            o_dec.prev  = {i_prev[31:24],
                           i_prev[23:16] + w_lg + {4'd0, i_byte[3:0]} - 8'd8,
                           i_prev[15:8] + w_lg,
                           i_prev[7:0] + w_lg + {4'd0, i_byte[7:4]} - 8'd8};
            o_dec.phase = 3'd0;
            o_dec.reps  = 7'd1;
        end else begin
            o_dec.prev[{w_sel, 3'b000} +: 8] = i_byte;
            if ((i_kind == KIND_RGB && i_phase >= 3'd3) || i_phase >= 3'd4) begin
                o_dec.phase = 3'd0;
                o_dec.reps  = 7'd1;
            end else begin
                o_dec.phase = i_phase + 3'd1;
            end
        end
    end

endmodule

### design/qoi_decoder_rgb565_alpha.sv
// top level of the qoi chunk stream decoder with rgb565 plus alpha output
// depends on qoid_pkg, qoid_index (with qoid_ram) and qoid_decode
//
// usage:
//   slave stream: one compressed byte per beat in s_tdata[7:0]; s_tlast
//   marks the last byte of an image. master stream: one result per beat,
//   m_tuser = has_pixel, m_tlast = image end, m_tdata carries the pixel,
//   alpha, last-of-input flag and end status.
//   config channel: index 0 writes image width, index 1 image height; the
//   pixel total is a registered product, so input is held off after a
//   write until the new total is registered.
// timing:
//   a byte passes through accept, index read and decode, and pixel count
//   and index write, then gives one result per cycle while the receiver
//   is ready. the registered read of the colour index ram sets the decode
//   step. one byte is in work at a time.
// reset and stall:
//   reset sets width and height to one and clears all image state; the
//   colour index is cleared by valid bits, so no clearing pass runs.
//   a stalled receiver holds the output register and the emit loop waits;
//   the next byte may be accepted while the last result is still held.
//   after the final byte's last result, all image state returns to reset.
module qoi_decoder_rgb565_alpha
    import qoid_pkg::*;
#(
    parameter int INDEX_ENTRIES = INDEX_ENTRIES_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // slave stream
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [7:0]  i_s_tdata,   // [7:0] data_byte
    input  logic        i_s_tlast,   // final_byte
    // master stream
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [31:0] o_m_tdata,   // [15:0] pixel_rgb565, [23:16] alpha,
                                     // [24] last_of_input, [26:25] end_status
    output logic        o_m_tuser,   // has_pixel
    output logic        o_m_tlast,   // image_end
    // configuration writes
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic        i_cfg_index,
    input  logic [15:0] i_cfg_data
);

    localparam int AW = $clog2(INDEX_ENTRIES);

    typedef enum logic [3:0] {
        S_IDLE   = 4'b0001,
        S_DECODE = 4'b0010,
        S_EMIT   = 4'b0100,
        S_OUT    = 4'b1000
    } t_state;

    t_state      r_state, n_state;
    logic [7:0]  r_byte;
    logic        r_fin;
    logic [31:0] r_prev, n_prev;
    logic [2:0]  r_phase, n_phase;
    logic [1:0]  r_kind, n_kind;
    logic [5:0]  r_luma, n_luma;
    logic [31:0] r_pd, n_pd;
    logic [1:0]  r_err, n_err;
    logic [6:0]  r_reps, n_reps;
    logic [6:0]  r_left, n_left;

    logic [15:0] r_width;
    logic [15:0] r_height;
    logic [31:0] r_total;
    logic        r_total_ok;

    logic        r_out_valid, n_out_valid;
    logic        r_out_has, n_out_has;
    logic [15:0] r_out_rgb, n_out_rgb;
    logic [7:0]  r_out_a, n_out_a;
    logic        r_out_lst, n_out_lst;
    logic        r_out_end, n_out_end;
    logic [1:0]  r_out_st, n_out_st;

    logic        w_in_acc;
    logic        w_out_free;
    logic [31:0] w_idx_q;
    logic        w_idx_wr;
    logic        w_idx_clr;
    t_dec        w_dec;
    logic [31:0] w_avail;
    logic        w_over;
    logic [6:0]  w_cap;
    logic [1:0]  w_status;
    logic [7:0]  w_hash;

    assign o_cfg_ready = 1'b1;
    assign o_s_tready  = (r_state == S_IDLE) && r_total_ok && !i_cfg_valid;
    assign w_in_acc    = i_s_tvalid && o_s_tready;
    assign w_out_free  = !r_out_valid || i_m_tready;

    // configuration registers and registered pixel total
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width    <= 16'd1;
            r_height   <= 16'd1;
            r_total    <= 32'd1;
            r_total_ok <= 1'b1;
        end else begin
            r_total    <= {16'd0, r_width} * {16'd0, r_height};
            r_total_ok <= !(i_cfg_valid && o_cfg_ready);
            if (i_cfg_valid && o_cfg_ready) begin
                unique case (i_cfg_index)
                    REG_WIDTH:  r_width  <= i_cfg_data;
                    REG_HEIGHT: r_height <= i_cfg_data;
                    default:    r_width  <= r_width;
                endcase
            end
        end
    end

    // accepted byte
    always_ff @(posedge i_clk) begin
        if (w_in_acc) begin
            r_byte <= i_s_tdata;
            r_fin  <= i_s_tlast;
        end
    end

    // colour index read at accept, written when a pixel is produced
    assign w_hash   = hash8(r_prev);
    assign w_idx_wr = (r_state == S_EMIT) && (w_cap != 7'd0);

    qoid_index #(
        .INDEX_ENTRIES (INDEX_ENTRIES),
        .AW            (AW)
    ) u_index (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_clr     (w_idx_clr),
        .i_rd_en   (w_in_acc),
        .i_rd_addr (i_s_tdata[AW-1:0]),
        .o_rd_data (w_idx_q),
        .i_wr_en   (w_idx_wr),
        .i_wr_addr (w_hash[AW-1:0]),
        .i_wr_data (r_prev)
    );

    qoid_decode u_decode (
        .i_byte     (r_byte),
        .i_prev     (r_prev),
        .i_idx_data (w_idx_q),
        .i_phase    (r_phase),
        .i_kind     (r_kind),
        .i_luma     (r_luma),
        .i_img_full (r_pd >= r_total),
        .o_dec      (w_dec)
    );

    // pixels left in the image bound the repeat count
    assign w_avail  = (r_total > r_pd) ? (r_total - r_pd) : 32'd0;
    assign w_over   = {25'd0, r_reps} > w_avail;
    assign w_cap    = w_over ? w_avail[6:0] : r_reps;
    assign w_status = (r_phase != 3'd0 || r_pd < r_total) ? ST_SHORT : r_err;

    always_comb begin
        n_state     = r_state;
        n_prev      = r_prev;
        n_phase     = r_phase;
        n_kind      = r_kind;
        n_luma      = r_luma;
        n_pd        = r_pd;
        n_err       = r_err;
        n_reps      = r_reps;
        n_left      = r_left;
        n_out_valid = r_out_valid && !i_m_tready;
        n_out_has   = r_out_has;
        n_out_rgb   = r_out_rgb;
        n_out_a     = r_out_a;
        n_out_lst   = r_out_lst;
        n_out_end   = r_out_end;
        n_out_st    = r_out_st;
        w_idx_clr   = 1'b0;

        unique case (r_state)
            S_IDLE: begin
                if (w_in_acc) begin
                    n_state = S_DECODE;
                end
            end
            S_DECODE: begin
                n_prev  = w_dec.prev;
                n_phase = w_dec.phase;
                n_kind  = w_dec.kind;
                n_luma  = w_dec.luma;
                n_reps  = w_dec.reps;
                if (w_dec.extra && r_err == ST_OK) begin
                    n_err = ST_EXTRA;
                end
                n_state = S_EMIT;
            end
            S_EMIT: begin
                if (w_over) begin
                    n_err = ST_OVERRUN;
                end
                n_pd    = r_pd + {25'd0, w_cap};
                n_left  = w_cap;
                n_state = (w_cap != 7'd0 || r_fin) ? S_OUT : S_IDLE;
            end
            S_OUT: begin
                if (w_out_free) begin
                    n_out_valid = 1'b1;
                    n_out_has   = r_left != 7'd0;
                    n_out_rgb   = (r_left != 7'd0) ? to565(r_prev) : 16'd0;
                    n_out_a     = (r_left != 7'd0) ? r_prev[31:24] : 8'd0;
                    n_out_lst   = r_left <= 7'd1;
                    n_out_end   = r_fin && r_left <= 7'd1;
                    n_out_st    = (r_fin && r_left <= 7'd1) ? w_status : ST_OK;
                    if (r_left <= 7'd1) begin
                        n_state = S_IDLE;
                        // final byte done: start a fresh image
                        if (r_fin) begin
                            n_prev    = PREV_RESET;
                            n_phase   = 3'd0;
                            n_kind    = KIND_RGB;
                            n_luma    = 6'd0;
                            n_pd      = 32'd0;
                            n_err     = ST_OK;
                            w_idx_clr = 1'b1;
                        end
                    end else begin
                        n_left = r_left - 7'd1;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_prev      <= PREV_RESET;
            r_phase     <= 3'd0;
            r_kind      <= KIND_RGB;
            r_luma      <= 6'd0;
            r_pd        <= 32'd0;
            r_err       <= ST_OK;
            r_reps      <= 7'd0;
            r_left      <= 7'd0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_prev      <= n_prev;
            r_phase     <= n_phase;
            r_kind      <= n_kind;
            r_luma      <= n_luma;
            r_pd        <= n_pd;
            r_err       <= n_err;
            r_reps      <= n_reps;
            r_left      <= n_left;
            r_out_valid <= n_out_valid;
        end
    end

    // output payload register
    always_ff @(posedge i_clk) begin
        r_out_has <= n_out_has;
        r_out_rgb <= n_out_rgb;
        r_out_a   <= n_out_a;
        r_out_lst <= n_out_lst;
        r_out_end <= n_out_end;
        r_out_st  <= n_out_st;
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {5'd0, r_out_st, r_out_lst, r_out_a, r_out_rgb};
    assign o_m_tuser  = r_out_has;
    assign o_m_tlast  = r_out_end;

    // an image end is always the last result of its byte
    a_end_is_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_out_end |-> r_out_lst)
        else $error("image end without last-of-input");

    // a result without a pixel only closes an image
    a_empty_ends_image: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && !r_out_has |-> r_out_end)
        else $error("pixel-less result outside image end");

    // index write never meets a read of a newly accepted byte
    a_no_rw_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_idx_wr |-> !w_in_acc)
        else $error("colour index read and write overlap");

    a_state_onehot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot(r_state))
        else $error("state register not one-hot");

endmodule
